### sv/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Beat types, register indexes and fixed constants of the echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

    localparam int TICK_W      = 32;
    localparam int RANGE_W     = 10;
    localparam int BLANK_W     = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;

    // round trip ticks to cm: rt * 1115 / 2^16 (about 0.017014 cm per us)
    localparam int SCALE_MUL_W = 11;
    localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = 11'd1115;
    localparam int SCALE_SHIFT = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_MIN_RANGE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_RANGE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BLANK     = 2'd2;

    localparam logic [RANGE_W-1:0] MIN_RANGE_RST = 10'd2;
    localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 10'd400;
    localparam logic [BLANK_W-1:0] BLANK_RST     = 16'd100;

    localparam logic CMD_TRIGGER = 1'b0;
    localparam logic CMD_ECHO    = 1'b1;
    localparam logic LEVEL_RISE  = 1'b1;

    typedef struct packed {
        logic              command;
        logic              level;
        logic [TICK_W-1:0] tick;
    } t_in_beat;

    typedef struct packed {
        logic [RANGE_W-1:0] range_cm;
        logic               changed;
    } t_out_beat;

endpackage

### sv/uer_scale.sv
// ----------------------------------------------------------------------------
// uer_scale
// Converts a signed round-trip tick count to a clamped distance in cm and
// flags a change against the previous reading.
// ----------------------------------------------------------------------------
module uer_scale #(
    parameter int TICK_BITS = 32
) (
    input  logic [TICK_BITS-1:0]          i_rt,
    input  logic [uer_pkg::RANGE_W-1:0]   i_min_range,
    input  logic [uer_pkg::RANGE_W-1:0]   i_max_range,
    input  logic [uer_pkg::RANGE_W-1:0]   i_prev_range,
    output logic [uer_pkg::RANGE_W-1:0]   o_range,
    output logic                          o_changed
);

    localparam int PROD_W = TICK_BITS + uer_pkg::SCALE_MUL_W;
    localparam int DIST_W = PROD_W - uer_pkg::SCALE_SHIFT;

    logic                 rt_neg;
    logic [TICK_BITS-1:0] rt_mag;
    logic [PROD_W-1:0]    prod;
    logic [DIST_W-1:0]    dist_mag;
    logic [DIST_W-1:0]    min_ext;
    logic [DIST_W-1:0]    max_ext;
    logic                 dist_neg;
    logic                 ge_min;
    logic                 le_max;
    logic                 gt_max;

    // scale the magnitude so the result truncates toward zero
    assign rt_neg   = i_rt[TICK_BITS-1];
    assign rt_mag   = rt_neg ? (~i_rt + 1'b1) : i_rt;
    assign prod     = PROD_W'(rt_mag) * PROD_W'(uer_pkg::SCALE_MUL);
    assign dist_mag = prod[PROD_W-1:uer_pkg::SCALE_SHIFT];
    assign dist_neg = rt_neg && (dist_mag != '0);

    assign min_ext = DIST_W'(i_min_range);
    assign max_ext = DIST_W'(i_max_range);
    assign ge_min  = !dist_neg && (dist_mag >= min_ext);
    assign le_max  = dist_neg || (dist_mag <= max_ext);
    assign gt_max  = !dist_neg && (dist_mag > max_ext);

    always_comb begin
        priority if (ge_min && le_max) begin
            o_range = dist_mag[uer_pkg::RANGE_W-1:0];
        end else if (gt_max) begin
            o_range = i_max_range;
        end else begin
            o_range = i_min_range;
        end
    end

    assign o_changed = (o_range != i_prev_range);

endmodule

### sv/ultrasonic_echo_ranger_top.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_top
// Echo pulse timer: pin edge events in, clamped distance readings out.
// ----------------------------------------------------------------------------
// One edge event is taken every clock cycle unless the input is stalled. Trigger
// and echo bookkeeping settles in the cycle the event is taken; an echo falling
// edge that closes a measurement yields its reading after the round-trip
// subtract and then the constant multiply and clamp, each behind its own
// register. All other events yield no reading. The input stalls only while a
// measurement waits behind a reading the sink has not yet taken.
module ultrasonic_echo_ranger_top #(
    parameter int TICK_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [uer_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [uer_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  uer_pkg::t_in_beat               i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output uer_pkg::t_out_beat              o_out
);

    logic [uer_pkg::RANGE_W-1:0] r_min_range;
    logic [uer_pkg::RANGE_W-1:0] r_max_range;
    logic [uer_pkg::BLANK_W-1:0] r_blank;

    logic                        r_armed;
    logic                        r_echo_started;
    logic [TICK_BITS-1:0]        r_trigger_time;
    logic [TICK_BITS-1:0]        r_echo_time;
    logic [uer_pkg::RANGE_W-1:0] r_prev_range;

    logic                        r_s1_valid;
    logic [TICK_BITS-1:0]        r_rt;
    logic                        r_out_valid;
    uer_pkg::t_out_beat          r_out;

    logic                        in_accept;
    logic                        out_load;
    logic [TICK_BITS-1:0]        tick;
    logic [TICK_BITS-1:0]        d_trig;
    logic [TICK_BITS:0]          blank_ext;
    logic                        past_blank;
    logic                        is_trigger;
    logic                        is_rise;
    logic                        take_rise;
    logic                        fire;

    logic                        n_armed;
    logic                        n_echo_started;
    logic [TICK_BITS-1:0]        n_trigger_time;
    logic [TICK_BITS-1:0]        n_echo_time;

    logic [uer_pkg::RANGE_W-1:0] range_calc;
    logic                        changed_calc;

    assign out_load   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !out_load;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign tick       = i_in.tick[TICK_BITS-1:0];
    assign d_trig     = tick - r_trigger_time;
    assign blank_ext  = (TICK_BITS+1)'(r_blank);
    // signed distance from trigger must be positive and above the blanking time
    assign past_blank = !d_trig[TICK_BITS-1] && ({1'b0, d_trig} > blank_ext);

    assign is_trigger = (i_in.command == uer_pkg::CMD_TRIGGER);
    assign is_rise    = (i_in.level == uer_pkg::LEVEL_RISE);
    assign take_rise  = !is_trigger && is_rise && r_armed && past_blank;
    assign fire       = !is_trigger && !is_rise && r_echo_started;

    always_comb begin
        n_armed        = r_armed;
        n_echo_started = r_echo_started;
        n_trigger_time = r_trigger_time;
        n_echo_time    = r_echo_time;
        priority if (is_trigger) begin
            n_armed        = 1'b1;
            n_echo_started = 1'b0;
            n_trigger_time = tick;
        end else if (take_rise) begin
            n_echo_started = 1'b1;
            n_echo_time    = tick;
        end else if (fire) begin
            n_echo_started = 1'b0;
            n_armed        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_range <= uer_pkg::MIN_RANGE_RST;
            r_max_range <= uer_pkg::MAX_RANGE_RST;
            r_blank     <= uer_pkg::BLANK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                uer_pkg::REG_MIN_RANGE: r_min_range <= i_cfg_wdata[uer_pkg::RANGE_W-1:0];
                uer_pkg::REG_MAX_RANGE: r_max_range <= i_cfg_wdata[uer_pkg::RANGE_W-1:0];
                uer_pkg::REG_BLANK:     r_blank     <= i_cfg_wdata[uer_pkg::BLANK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed        <= 1'b0;
            r_echo_started <= 1'b0;
            r_trigger_time <= '0;
            r_echo_time    <= '0;
            r_s1_valid     <= 1'b0;
        end else if (in_accept) begin
            r_armed        <= n_armed;
            r_echo_started <= n_echo_started;
            r_trigger_time <= n_trigger_time;
            r_echo_time    <= n_echo_time;
            r_s1_valid     <= fire;
        end else if (out_load) begin
            r_s1_valid     <= 1'b0;
        end
    end

    // round trip, wrapping, read as signed downstream
    always_ff @(posedge i_clk) begin
        if (in_accept && fire) begin
            r_rt <= tick - r_echo_time;
        end
    end

    uer_scale #(
        .TICK_BITS (TICK_BITS)
    ) u_scale (
        .i_rt         (r_rt),
        .i_min_range  (r_min_range),
        .i_max_range  (r_max_range),
        .i_prev_range (r_prev_range),
        .o_range      (range_calc),
        .o_changed    (changed_calc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_prev_range <= '0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_prev_range <= range_calc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid) begin
            r_out.range_cm <= range_calc;
            r_out.changed  <= changed_calc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### sv/uer_checker.sv
// ----------------------------------------------------------------------------
// uer_checker
// Port-level checks of the echo ranger, bound to the top level.
// ----------------------------------------------------------------------------
module uer_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input uer_pkg::t_out_beat              o_out
);

    logic [uer_pkg::RANGE_W-1:0] r_last_range;
    logic                        out_beat;

    assign out_beat = o_out_valid && !i_out_stall;

    // track the last reading the sink took
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_range <= '0;
        end else if (out_beat) begin
            r_last_range <= o_out.range_cm;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("output beat dropped or changed while stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked output beat");

    a_changed_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat |-> (o_out.changed == (o_out.range_cm != r_last_range)))
        else $error("changed flag disagrees with previous reading");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output valid or input stall after reset");

endmodule

bind ultrasonic_echo_ranger_top uer_checker u_uer_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
